>>> src/sipc_pkg.sv
`default_nettype none
package sipc_pkg;
  localparam int unsigned COORD_BITS_DEF = 16;
endpackage
`default_nettype wire

>>> src/sipc_if.sv
`default_nettype none
interface sipc_in_if #(
  parameter int unsigned CoordBits = sipc_pkg::COORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] seg1_start_x;
  logic signed [CoordBits-1:0] seg1_start_y;
  logic signed [CoordBits-1:0] seg1_end_x;
  logic signed [CoordBits-1:0] seg1_end_y;
  logic signed [CoordBits-1:0] seg2_start_x;
  logic signed [CoordBits-1:0] seg2_start_y;
  logic signed [CoordBits-1:0] seg2_end_x;
  logic signed [CoordBits-1:0] seg2_end_y;

  modport source (
    output valid, seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
           seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y,
    input  ready
  );
  modport sink (
    input  valid, seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
           seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y,
    output ready
  );
endinterface

interface sipc_out_if #(
  parameter int unsigned CoordBits = sipc_pkg::COORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic signed [CoordBits-1:0] point_x;
  logic signed [CoordBits-1:0] point_y;

  modport source (output valid, hit, point_x, point_y, input ready);
  modport sink (input valid, hit, point_x, point_y, output ready);
endinterface
`default_nettype wire

>>> src/sipc_div.sv
`default_nettype none
module sipc_div #(
  parameter int unsigned COORD_BITS = sipc_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic                              neg_i,
  input  logic [3*(COORD_BITS+1)-1:0]       mag_i,
  input  logic [2*(COORD_BITS+1)-1:0]       det_i,
  input  logic signed [COORD_BITS-1:0]      s_i,
  output logic signed [COORD_BITS-1:0]      point_o
);
  import sipc_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned H  = CB + 1;
  localparam int unsigned W  = 2 * H;
  localparam int unsigned V  = CB + 2;

  logic [W:0]             rem_q [0:CB];
  logic [CB-1:0]          low_q [0:CB];
  logic [CB-1:0]          quo_q [0:CB];
  logic [W-1:0]           det_q [0:CB];
  logic                   neg_q [0:CB];
  logic signed [CB-1:0]   s_q   [0:CB];

  logic [W:0]             tr    [1:CB];
  logic                   ge    [1:CB];
  logic [W:0]             rem_d [1:CB];
  logic [CB-1:0]          quo_d [1:CB];
  logic [CB-1:0]          low_d [1:CB];

  logic signed [V-1:0]    sw;
  logic signed [V-1:0]    qw;
  logic signed [V-1:0]    base;
  logic signed [V-1:0]    res;
  logic                   ra;
  logic signed [CB-1:0]   point_q;

  // one quotient bit per stage
  always_comb begin
    for (int k = 1; k <= CB; k++) begin
      tr[k]    = {rem_q[k-1][W-1:0], low_q[k-1][CB-1]};
      ge[k]    = tr[k] >= {1'b0, det_q[k-1]};
      rem_d[k] = ge[k] ? tr[k] - {1'b0, det_q[k-1]} : tr[k];
      quo_d[k] = {quo_q[k-1][CB-2:0], ge[k]};
      low_d[k] = {low_q[k-1][CB-2:0], 1'b0};
    end
  end

  // floor of the offset magnitude, then truncation of the whole point toward zero
  always_comb begin
    sw = {{(V-CB){s_q[CB][CB-1]}}, s_q[CB]};
    qw = {2'b00, quo_q[CB]};
    ra = rem_q[CB] != '0;
    if (neg_q[CB]) begin
      base = sw - qw;
      res  = (ra && (base - V'(1)) >= 0) ? base - V'(1) : base;
    end else begin
      base = sw + qw;
      res  = (ra && base < 0) ? base + V'(1) : base;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= mag_i[3*H-1:CB];
      low_q[0] <= mag_i[CB-1:0];
      quo_q[0] <= '0;
      det_q[0] <= det_i;
      neg_q[0] <= neg_i;
      s_q[0]   <= s_i;
      for (int k = 1; k <= CB; k++) begin
        rem_q[k] <= rem_d[k];
        low_q[k] <= low_d[k];
        quo_q[k] <= quo_d[k];
        det_q[k] <= det_q[k-1];
        neg_q[k] <= neg_q[k-1];
        s_q[k]   <= s_q[k-1];
      end
      point_q <= res[CB-1:0];
    end
  end

  assign point_o = point_q;
endmodule
`default_nettype wire

>>> src/segment_intersection_point_core.sv
// throughput: one item per cycle; a stalled output freezes the whole pipeline
// seven arithmetic stages, then a divider with one quotient bit per stage
// reset (async, active low) clears the valid bits only
`default_nettype none
module segment_intersection_point_core #(
  parameter int unsigned COORD_BITS = sipc_pkg::COORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sipc_in_if.sink     in_ch,
  sipc_out_if.source  out_ch
);
  import sipc_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned H  = CB + 1;
  localparam int unsigned W  = 2 * H;
  localparam int unsigned DL = CB + 2;

  function automatic logic signed [H-1:0] sx(input logic [CB-1:0] v);
    sx = {v[CB-1], v};
  endfunction

  logic en;

  // stage 1
  logic                 v1_q;
  logic signed [H-1:0]  d1x1_q, d1y1_q, d2x1_q, d2y1_q, ox1_q, oy1_q;
  logic signed [CB-1:0] s1x1_q, s1y1_q;
  // stage 2
  logic                 v2_q;
  logic signed [W-1:0]  pa_q, pb_q, pc_q, pd_q, pe_q, pf_q;
  logic signed [H-1:0]  d1x2_q, d1y2_q;
  logic signed [CB-1:0] s1x2_q, s1y2_q;
  // stage 3
  logic                 v3_q;
  logic signed [W:0]    det3_q, t13_q, t23_q;
  logic signed [H-1:0]  d1x3_q, d1y3_q;
  logic signed [CB-1:0] s1x3_q, s1y3_q;
  // stage 4
  logic                 v4_q;
  logic signed [W:0]    det4_q, t14_q, t24_q;
  logic signed [H-1:0]  d1x4_q, d1y4_q;
  logic signed [CB-1:0] s1x4_q, s1y4_q;
  // stage 5
  logic                 v5_q, h5_q;
  logic [W-1:0]         det5_q, t15_q;
  logic [CB-1:0]        dxm5_q, dym5_q;
  logic                 dxn5_q, dyn5_q;
  logic signed [CB-1:0] s1x5_q, s1y5_q;
  logic signed [H-1:0]  dxa, dya;
  // stage 6
  logic                 v6_q, h6_q;
  logic [W-1:0]         det6_q;
  logic [W-1:0]         pxl_q, pxh_q, pyl_q, pyh_q;
  logic                 dxn6_q, dyn6_q;
  logic signed [CB-1:0] s1x6_q, s1y6_q;
  // stage 7
  logic                 v7_q, h7_q;
  logic [W-1:0]         det7_q;
  logic [3*H-1:0]       mx7_q, my7_q;
  logic                 dxn7_q, dyn7_q;
  logic signed [CB-1:0] s1x7_q, s1y7_q;
  // divider alignment
  logic                 vd_q [0:DL-1];
  logic                 hd_q [0:DL-1];
  logic signed [CB-1:0] px, py;

  assign en          = !vd_q[DL-1] || out_ch.ready;
  assign in_ch.ready = en;

  assign dxa = d1x4_q[H-1] ? -d1x4_q : d1x4_q;
  assign dya = d1y4_q[H-1] ? -d1y4_q : d1y4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      for (int k = 0; k < DL; k++) begin
        vd_q[k] <= 1'b0;
      end
    end else if (en) begin
      v1_q <= in_ch.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      vd_q[0] <= v7_q;
      for (int k = 1; k < DL; k++) begin
        vd_q[k] <= vd_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // direction and offset vectors
      d1x1_q <= sx(in_ch.seg1_end_x) - sx(in_ch.seg1_start_x);
      d1y1_q <= sx(in_ch.seg1_end_y) - sx(in_ch.seg1_start_y);
      d2x1_q <= sx(in_ch.seg2_end_x) - sx(in_ch.seg2_start_x);
      d2y1_q <= sx(in_ch.seg2_end_y) - sx(in_ch.seg2_start_y);
      ox1_q  <= sx(in_ch.seg2_start_x) - sx(in_ch.seg1_start_x);
      oy1_q  <= sx(in_ch.seg2_start_y) - sx(in_ch.seg1_start_y);
      s1x1_q <= in_ch.seg1_start_x;
      s1y1_q <= in_ch.seg1_start_y;
      // cross products
      pa_q   <= d2x1_q * d1y1_q;
      pb_q   <= d1x1_q * d2y1_q;
      pc_q   <= d2x1_q * oy1_q;
      pd_q   <= d2y1_q * ox1_q;
      pe_q   <= d1x1_q * oy1_q;
      pf_q   <= d1y1_q * ox1_q;
      d1x2_q <= d1x1_q;
      d1y2_q <= d1y1_q;
      s1x2_q <= s1x1_q;
      s1y2_q <= s1y1_q;
      // determinant and numerators
      det3_q <= {pa_q[W-1], pa_q} - {pb_q[W-1], pb_q};
      t13_q  <= {pc_q[W-1], pc_q} - {pd_q[W-1], pd_q};
      t23_q  <= {pe_q[W-1], pe_q} - {pf_q[W-1], pf_q};
      d1x3_q <= d1x2_q;
      d1y3_q <= d1y2_q;
      s1x3_q <= s1x2_q;
      s1y3_q <= s1y2_q;
      // sign normalization
      det4_q <= det3_q[W] ? -det3_q : det3_q;
      t14_q  <= det3_q[W] ? -t13_q : t13_q;
      t24_q  <= det3_q[W] ? -t23_q : t23_q;
      d1x4_q <= d1x3_q;
      d1y4_q <= d1y3_q;
      s1x4_q <= s1x3_q;
      s1y4_q <= s1y3_q;
      // range test
      h5_q   <= (det4_q != '0) && !t14_q[W] && !t24_q[W] &&
                (t14_q <= det4_q) && (t24_q <= det4_q);
      det5_q <= det4_q[W-1:0];
      t15_q  <= t14_q[W-1:0];
      dxm5_q <= dxa[CB-1:0];
      dym5_q <= dya[CB-1:0];
      dxn5_q <= d1x4_q[H-1];
      dyn5_q <= d1y4_q[H-1];
      s1x5_q <= s1x4_q;
      s1y5_q <= s1y4_q;
      // partial products of t1 * |dir|
      pxl_q  <= W'(t15_q[H-1:0]) * W'(dxm5_q);
      pxh_q  <= W'(t15_q[W-1:H]) * W'(dxm5_q);
      pyl_q  <= W'(t15_q[H-1:0]) * W'(dym5_q);
      pyh_q  <= W'(t15_q[W-1:H]) * W'(dym5_q);
      h6_q   <= h5_q;
      det6_q <= det5_q;
      dxn6_q <= dxn5_q;
      dyn6_q <= dyn5_q;
      s1x6_q <= s1x5_q;
      s1y6_q <= s1y5_q;
      // combine partial products
      mx7_q  <= ({{H{1'b0}}, pxh_q} << H) + {{H{1'b0}}, pxl_q};
      my7_q  <= ({{H{1'b0}}, pyh_q} << H) + {{H{1'b0}}, pyl_q};
      h7_q   <= h6_q;
      det7_q <= det6_q;
      dxn7_q <= dxn6_q;
      dyn7_q <= dyn6_q;
      s1x7_q <= s1x6_q;
      s1y7_q <= s1y6_q;
      hd_q[0] <= h7_q;
      for (int k = 1; k < DL; k++) begin
        hd_q[k] <= hd_q[k-1];
      end
    end
  end

  sipc_div #(.COORD_BITS(CB)) u_div_x (
    .clk_i   (clk_i),
    .en_i    (en),
    .neg_i   (dxn7_q),
    .mag_i   (mx7_q),
    .det_i   (det7_q),
    .s_i     (s1x7_q),
    .point_o (px)
  );

  sipc_div #(.COORD_BITS(CB)) u_div_y (
    .clk_i   (clk_i),
    .en_i    (en),
    .neg_i   (dyn7_q),
    .mag_i   (my7_q),
    .det_i   (det7_q),
    .s_i     (s1y7_q),
    .point_o (py)
  );

  assign out_ch.valid   = vd_q[DL-1];
  assign out_ch.hit     = hd_q[DL-1];
  assign out_ch.point_x = hd_q[DL-1] ? px : '0;
  assign out_ch.point_y = hd_q[DL-1] ? py : '0;
endmodule
`default_nettype wire
